// ===== rtl/selective_repeat_sender_window_unit_defines.svh =====
// Assertion macros used by the checker file of the sender window unit.
// Depends on nothing; the using module must have i_clk and i_rst_n in scope.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_DEFINES_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SRSW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SRSW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/srsw_pkg.sv =====
// Package of the selective-repeat sender window: codes, types and helpers.
// Depends on nothing; used by every other file of the block but the defines header.
`timescale 1ns / 1ps

package srsw_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int SEQ_W         = 33;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [1:0] CMD_TICK = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_ERR  = 2'd2;

    localparam logic [2:0] ST_RUNNING  = 3'd0;
    localparam logic [2:0] ST_COMPLETE = 3'd1;
    localparam logic [2:0] ST_SRV_ERR  = 3'd2;
    localparam logic [2:0] ST_RETRY    = 3'd3;
    localparam logic [2:0] ST_NO_SRV   = 3'd4;
    localparam logic [2:0] ST_SRV_DOWN = 3'd5;

    localparam logic [1:0] PT_START = 2'd0;
    localparam logic [1:0] PT_DATA  = 2'd1;
    localparam logic [1:0] PT_FIN   = 2'd2;

    localparam logic KIND_SEND   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_LAST_SEQ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIN_SIZE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RETX     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SRV_TO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RETRY    = 3'd4;

    typedef enum logic [1:0] {
        SEL_NEXT,
        SEL_ACK,
        SEL_BASE,
        SEL_CUR
    } t_sel;

    typedef struct packed {
        logic load;
        logic set_complete;
        logic init_step;
        logic clear_send;
        logic age;
        logic heard;
        logic srv_err;
        logic mark;
        logic slide;
        logic emit_send;
        logic init_scan;
        logic scan_skip;
        logic scan_fail;
        logic resend;
        logic timeout;
        logic emit_status;
        t_sel sel;
    } t_dp_cmd;

    typedef struct packed {
        logic finished;
        logic can_send;
        logic cmd_ack;
        logic cmd_err;
        logic ack_in_win;
        logic slide_ok;
        logic emit_more;
        logic scan_more;
        logic scan_due;
        logic retry_out;
        logic fs_nz;
        logic out_free;
    } t_dp_stat;

    // Packet type of a sequence number: start, fin or data.
    function automatic logic [1:0] type_of(input logic [SEQ_W-1:0] seq,
                                           input logic [31:0] last);
        logic [1:0] res;
        if (seq == '0) begin
            res = PT_START;
        end else if (seq == {1'b0, last}) begin
            res = PT_FIN;
        end else begin
            res = PT_DATA;
        end
        return res;
    endfunction

endpackage

// ===== rtl/srsw_ifs.sv =====
// Handshake interfaces of the sender window: input, result and register write channels.
// Depends on srsw_pkg for the field widths.
`timescale 1ns / 1ps

interface srsw_in_if
    import srsw_pkg::*;
();
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [31:0] ack_sequence;
    modport source(output valid, command, ack_sequence, input ready);
    modport sink(input valid, command, ack_sequence, output ready);
endinterface

interface srsw_out_if
    import srsw_pkg::*;
();
    logic        valid;
    logic        ready;
    logic        kind;
    logic [31:0] sequence_res;
    logic [1:0]  packet_type;
    logic        is_retransmission;
    logic [2:0]  status;
    logic [31:0] window_base;
    logic        is_last;
    modport source(output valid, kind, sequence_res, packet_type, is_retransmission,
                   status, window_base, is_last, input ready);
    modport sink(input valid, kind, sequence_res, packet_type, is_retransmission,
                 status, window_base, is_last, output ready);
endinterface

interface srsw_cfg_if
    import srsw_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/srsw_ctrl.sv =====
// Step sequencer of the sender window: walks the phases of one poll period.
// Depends on srsw_pkg; drives the datapath through t_dp_cmd and reads t_dp_stat.
`timescale 1ns / 1ps

module srsw_ctrl
    import srsw_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_CHECK   = 10'b00_0000_0010,
        S_SEND    = 10'b00_0000_0100,
        S_AGE     = 10'b00_0000_1000,
        S_ACK     = 10'b00_0001_0000,
        S_SLIDE   = 10'b00_0010_0000,
        S_EMIT    = 10'b00_0100_0000,
        S_SCAN    = 10'b00_1000_0000,
        S_TIMEOUT = 10'b01_0000_0000,
        S_STATUS  = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_cmd.sel  = SEL_CUR;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_stat.finished) begin
                    o_cmd.set_complete = 1'b1;
                    n_state            = S_STATUS;
                end else begin
                    o_cmd.init_step = 1'b1;
                    n_state         = S_SEND;
                end
            end
            S_SEND: begin
                o_cmd.sel = SEL_NEXT;
                if (i_stat.can_send) begin
                    o_cmd.clear_send = 1'b1;
                end else begin
                    n_state = S_AGE;
                end
            end
            S_AGE: begin
                o_cmd.age = 1'b1;
                if (i_stat.cmd_err) begin
                    o_cmd.srv_err = 1'b1;
                    n_state       = S_EMIT;
                end else if (i_stat.cmd_ack) begin
                    o_cmd.heard = 1'b1;
                    n_state     = S_ACK;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ACK: begin
                o_cmd.sel  = SEL_ACK;
                o_cmd.mark = i_stat.ack_in_win;
                n_state    = S_SLIDE;
            end
            S_SLIDE: begin
                o_cmd.sel = SEL_BASE;
                if (i_stat.slide_ok) begin
                    o_cmd.slide = 1'b1;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_stat.emit_more) begin
                    o_cmd.emit_send = i_stat.out_free;
                end else if (i_stat.fs_nz) begin
                    n_state = S_STATUS;
                end else begin
                    o_cmd.init_scan = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!i_stat.scan_more) begin
                    n_state = S_TIMEOUT;
                end else if (!i_stat.scan_due) begin
                    o_cmd.scan_skip = 1'b1;
                end else if (i_stat.retry_out) begin
                    o_cmd.scan_fail = 1'b1;
                    n_state         = S_STATUS;
                end else begin
                    o_cmd.resend = i_stat.out_free;
                end
            end
            S_TIMEOUT: begin
                o_cmd.timeout = 1'b1;
                n_state       = S_STATUS;
            end
            S_STATUS: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_status = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/srsw_dp.sv =====
// Datapath of the sender window: registers, slot state, counters and result register.
// Depends on srsw_pkg and srsw_ifs; commanded by srsw_ctrl.
`timescale 1ns / 1ps

module srsw_dp
    import srsw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    srsw_cfg_if.sink       i_cfg,
    input  logic [1:0]     i_command,
    input  logic [31:0]    i_ack_sequence,
    srsw_out_if.source     o_out,
    input  t_dp_cmd        i_cmd,
    output t_dp_stat       o_stat
);

    localparam int SW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [SW-1:0] SLOT_TOP = SW'(WINDOW_DEPTH - 1);
    localparam logic [SW:0]   DEPTH_W  = (SW+1)'(WINDOW_DEPTH);
    localparam logic [15:0]   AGE_MAX  = 16'hFFFF;

    // Configuration registers.
    logic [31:0] r_last;
    logic [5:0]  r_win_cfg;
    logic [15:0] r_retx;
    logic [15:0] r_srv_to;
    logic [2:0]  r_retry_lim;

    logic [1:0]       r_cmd;
    logic [31:0]      r_ack;
    logic [SEQ_W-1:0] r_base, r_next, r_old_next, r_cur;
    logic [SW-1:0]    r_base_slot, r_next_slot, r_cur_slot;
    logic             r_acked [WINDOW_DEPTH];
    logic [15:0]      r_age   [WINDOW_DEPTH];
    logic [2:0]       r_retry [WINDOW_DEPTH];
    logic             r_heard;
    logic [15:0]      r_silence;
    logic [2:0]       r_fs;

    logic        r_ov;
    logic        r_kind;
    logic [31:0] r_oseq;
    logic [1:0]  r_optype;
    logic        r_oretx;
    logic [2:0]  r_ostatus;
    logic [31:0] r_obase;
    logic        r_olast;

    logic [5:0]       win;
    logic [SEQ_W-1:0] ack_w, ack_diff, in_flight;
    logic [SW:0]      ack_sum;
    logic [SW-1:0]    ack_slot, idx;
    logic             rd_acked;
    logic [15:0]      rd_age;
    logic [2:0]       rd_retry;
    logic             out_free, emit;

    function automatic logic [SW-1:0] inc_slot(input logic [SW-1:0] s);
        return (s == SLOT_TOP) ? '0 : s + 1'b1;
    endfunction

    assign i_cfg.ready = 1'b1;

    always_comb begin
        if (r_win_cfg == 6'd0) begin
            win = 6'd1;
        end else if ({1'b0, r_win_cfg} > 7'(WINDOW_DEPTH)) begin
            win = 6'(WINDOW_DEPTH);
        end else begin
            win = r_win_cfg;
        end
    end

    // An in-window ack lies less than the depth above the base, so one wrap suffices.
    assign ack_w     = {1'b0, r_ack};
    assign ack_diff  = ack_w - r_base;
    assign ack_sum   = {1'b0, r_base_slot} + {1'b0, ack_diff[SW-1:0]};
    assign ack_slot  = (ack_sum >= DEPTH_W) ? SW'(ack_sum - DEPTH_W) : ack_sum[SW-1:0];
    assign in_flight = r_next - r_base;

    always_comb begin
        case (i_cmd.sel)
            SEL_NEXT: idx = r_next_slot;
            SEL_ACK:  idx = ack_slot;
            SEL_BASE: idx = r_base_slot;
            default:  idx = r_cur_slot;
        endcase
    end

    assign rd_acked = r_acked[idx];
    assign rd_age   = r_age[idx];
    assign rd_retry = r_retry[idx];

    assign out_free = !r_ov || o_out.ready;
    assign emit     = i_cmd.emit_send || i_cmd.resend || i_cmd.emit_status;

    always_comb begin
        o_stat            = '0;
        o_stat.finished   = (r_fs != ST_RUNNING) || (r_base > {1'b0, r_last});
        o_stat.can_send   = (r_next <= {1'b0, r_last}) && (in_flight < SEQ_W'(win));
        o_stat.cmd_ack    = (r_cmd == CMD_ACK);
        o_stat.cmd_err    = (r_cmd == CMD_ERR);
        o_stat.ack_in_win = (ack_w >= r_base) && (ack_w < r_next);
        o_stat.slide_ok   = (r_base < r_next) && rd_acked;
        o_stat.emit_more  = (r_cur < r_next);
        o_stat.scan_more  = (r_cur < r_old_next);
        o_stat.scan_due   = !rd_acked && (rd_age >= r_retx);
        o_stat.retry_out  = (rd_retry >= r_retry_lim);
        o_stat.fs_nz      = (r_fs != ST_RUNNING);
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= 32'd1;
            r_win_cfg   <= 6'd8;
            r_retx      <= 16'd15;
            r_srv_to    <= 16'd600;
            r_retry_lim <= 3'd5;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LAST_SEQ: r_last      <= i_cfg.data;
                REG_WIN_SIZE: r_win_cfg   <= i_cfg.data[5:0];
                REG_RETX:     r_retx      <= i_cfg.data[15:0];
                REG_SRV_TO:   r_srv_to    <= i_cfg.data[15:0];
                REG_RETRY:    r_retry_lim <= i_cfg.data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd <= i_command;
            r_ack <= i_ack_sequence;
        end
        if (i_cmd.init_step) begin
            r_old_next <= r_next;
            r_cur      <= r_next;
        end else if (i_cmd.init_scan) begin
            r_cur      <= r_base;
            r_cur_slot <= r_base_slot;
        end else if (i_cmd.emit_send) begin
            r_cur <= r_cur + 1'b1;
        end else if (i_cmd.scan_skip || i_cmd.resend) begin
            r_cur      <= r_cur + 1'b1;
            r_cur_slot <= inc_slot(r_cur_slot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_next      <= '0;
            r_base_slot <= '0;
            r_next_slot <= '0;
            r_heard     <= 1'b0;
            r_silence   <= '0;
            r_fs        <= ST_RUNNING;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                r_acked[i] <= 1'b0;
                r_age[i]   <= '0;
                r_retry[i] <= '0;
            end
        end else begin
            if (i_cmd.clear_send) begin
                r_next      <= r_next + 1'b1;
                r_next_slot <= inc_slot(r_next_slot);
            end
            if (i_cmd.slide) begin
                r_base      <= r_base + 1'b1;
                r_base_slot <= inc_slot(r_base_slot);
            end
            if (i_cmd.age) begin
                if (i_cmd.heard || i_cmd.srv_err) begin
                    r_silence <= '0;
                    r_heard   <= 1'b1;
                end else if (r_silence != AGE_MAX) begin
                    r_silence <= r_silence + 1'b1;
                end
            end
            if (i_cmd.set_complete && r_fs == ST_RUNNING) begin
                r_fs <= ST_COMPLETE;
            end else if (i_cmd.srv_err) begin
                r_fs <= ST_SRV_ERR;
            end else if (i_cmd.scan_fail) begin
                r_fs <= ST_RETRY;
            end else if (i_cmd.timeout) begin
                if (r_silence >= r_srv_to) begin
                    r_fs <= r_heard ? ST_SRV_DOWN : ST_NO_SRV;
                end else if (r_base > {1'b0, r_last}) begin
                    r_fs <= ST_COMPLETE;
                end
            end
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                if (i_cmd.age) begin
                    if (r_age[i] != AGE_MAX) begin
                        r_age[i] <= r_age[i] + 1'b1;
                    end
                end else if (SW'(i) == idx) begin
                    if (i_cmd.clear_send) begin
                        r_acked[i] <= 1'b0;
                        r_age[i]   <= '0;
                        r_retry[i] <= '0;
                    end else if (i_cmd.mark) begin
                        r_acked[i] <= 1'b1;
                    end else if (i_cmd.slide) begin
                        r_acked[i] <= 1'b0;
                    end else if (i_cmd.resend) begin
                        r_age[i]   <= '0;
                        r_retry[i] <= r_retry[i] + 1'b1;
                    end
                end
            end
        end
    end

    // Result register: one request held until the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obase <= r_base[31:0];
            if (i_cmd.emit_status) begin
                r_kind    <= KIND_STATUS;
                r_oseq    <= '0;
                r_optype  <= PT_START;
                r_oretx   <= 1'b0;
                r_ostatus <= r_fs;
                r_olast   <= 1'b1;
            end else begin
                r_kind    <= KIND_SEND;
                r_oseq    <= r_cur[31:0];
                r_optype  <= type_of(r_cur, r_last);
                r_oretx   <= i_cmd.resend;
                r_ostatus <= ST_RUNNING;
                r_olast   <= 1'b0;
            end
        end
    end

    assign o_out.valid             = r_ov;
    assign o_out.kind              = r_kind;
    assign o_out.sequence_res      = r_oseq;
    assign o_out.packet_type       = r_optype;
    assign o_out.is_retransmission = r_oretx;
    assign o_out.status            = r_ostatus;
    assign o_out.window_base       = r_obase;
    assign o_out.is_last           = r_olast;

endmodule

// ===== rtl/selective_repeat_sender_window_unit.sv =====
// Top level of the selective-repeat sender window: joins sequencer and datapath.
// Depends on srsw_pkg, srsw_ifs, srsw_ctrl and srsw_dp.
`timescale 1ns / 1ps

// Each accepted request on i_in is one poll period of a selective-repeat sender.
// In it the block issues the new sequence numbers that the window allows, ages
// every slot, takes an acknowledgement or a server error, slides the window base,
// resends slots that have timed out and checks the server timeouts. Every period
// yields zero or more send requests and then exactly one status request, which
// carries is_last. window_base in every request of a period is the base after
// that period. One period at a time is worked on, in the steps new sends, ageing,
// acknowledgement and slide, emits of the new sends, a scan of the slots from the base
// to the old send point with resends, and the timeout check; o_out can hold back any
// request. The slot scan goes one slot per cycle, unless o_out holds back a resend,
// through a single read port of the slot state. Once a final status has been reached,
// each period yields only that status. Register writes on i_cfg are always taken and
// must come only while the block is idle.
module selective_repeat_sender_window_unit
    import srsw_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srsw_cfg_if.sink    i_cfg,
    srsw_in_if.sink     i_in,
    srsw_out_if.source  o_out
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;
    logic     in_ready;

    assign i_in.ready = in_ready;

    // The sequencer takes a request only when the previous period is closed.
    srsw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds all window state and the result register.
    srsw_dp #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (i_cfg),
        .i_command      (i_in.command),
        .i_ack_sequence (i_in.ack_sequence),
        .o_out          (o_out),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat)
    );

endmodule

// ===== rtl/srsw_checker.sv =====
// Port-level checks on the sender window, attached to the top level by bind.
// Depends on srsw_pkg and selective_repeat_sender_window_unit_defines.svh.
`timescale 1ns / 1ps
`include "selective_repeat_sender_window_unit_defines.svh"

module srsw_checker
    import srsw_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic       i_out_kind,
    input logic [2:0] i_out_status,
    input logic       i_out_is_last
);

    `SRSW_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid, "result dropped")
    `SRSW_ASSERT_NOW(a_last_is_status, i_out_valid, i_out_kind == i_out_is_last, "kind/is_last")
    `SRSW_ASSERT_NOW(a_send_running, i_out_valid && !i_out_kind, i_out_status == ST_RUNNING, "send status")
    `SRSW_ASSERT_NOW(a_idle_only_status, i_in_ready && i_out_valid, i_out_is_last, "early accept")
    `SRSW_ASSERT_NEXT(a_one_at_a_time, i_in_valid && i_in_ready, !i_in_ready, "double accept")

endmodule

bind selective_repeat_sender_window_unit srsw_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_kind    (o_out.kind),
    .i_out_status  (o_out.status),
    .i_out_is_last (o_out.is_last)
);

// ===== bench/tb_selective_repeat_sender_window_unit.sv =====
// Self-checking bench for the selective-repeat sender window unit.
// Depends on srsw_pkg, the srsw_ifs interfaces and the RTL of the unit.
`timescale 1ns / 1ps

module tb_selective_repeat_sender_window_unit;
    import srsw_pkg::*;

    // Command code 3 is not named by the package; the block treats it as a plain tick.
    localparam logic [1:0] CMD_SPARE = 2'd3;
    localparam int         LIMIT     = 600000;
    localparam int         SETTLE    = 150;
    localparam int         HOLD_LEN  = 400;

    typedef struct packed {
        logic        kind;
        logic [31:0] seq;
        logic [1:0]  ptype;
        logic        retx;
        logic [2:0]  status;
        logic [31:0] wbase;
        logic        is_last;
    } window_result_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ack;
    } poll_t;

    logic i_clk;
    logic i_rst_n;

    srsw_cfg_if cfg_ch ();
    srsw_in_if  in_ch ();
    srsw_out_if out_ch ();

    selective_repeat_sender_window_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // Mirror of the block: configuration registers and window state.
    logic [31:0] c_last;
    logic [5:0]  c_win;
    logic [15:0] c_retx;
    logic [15:0] c_srvto;
    logic [2:0]  c_retry;
    logic [32:0] base_q;
    logic [32:0] next_q;
    bit          acked [32];
    logic [15:0] age [32];
    logic [2:0]  retries [32];
    bit          heard;
    logic [15:0] silence;
    logic [2:0]  fstat;

    window_result_t expected_results[$];
    poll_t          pending_polls[$];

    int  mismatches;
    int  cycles;
    bit  calm;
    bit  hold_req;
    bit  hold_seen;
    int  hold_left;
    int  in_gap;
    int  out_gap;
    bit  in_fire;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [1:0] packet_kind(input logic [32:0] seq);
        if (seq == '0) return PT_START;
        if (seq == {1'b0, c_last}) return PT_FIN;
        return PT_DATA;
    endfunction

    function automatic window_result_t send_result(input logic [32:0] seq, input logic retx);
        window_result_t r;
        r.kind    = KIND_SEND;
        r.seq     = seq[31:0];
        r.ptype   = packet_kind(seq);
        r.retx    = retx;
        r.status  = ST_RUNNING;
        r.wbase   = '0;
        r.is_last = 1'b0;
        return r;
    endfunction

    // One poll period: new sends, ageing, acknowledgement, resends, timeouts.
    function automatic void advance_window(input logic [1:0] cmd, input logic [31:0] ack);
        window_result_t run[$];
        window_result_t st;
        logic [32:0]    win;
        logic [32:0]    old_next;
        logic [32:0]    s;
        bit             done;
        done = 0;
        old_next = next_q;
        if (fstat == ST_RUNNING && base_q > {1'b0, c_last}) fstat = ST_COMPLETE;
        if (fstat != ST_RUNNING) done = 1;
        if (!done) begin
            win = (c_win == 0) ? 33'd1 : (c_win > 32) ? 33'd32 : {27'd0, c_win};
            while (next_q <= {1'b0, c_last} && next_q - base_q < win) begin
                acked[next_q[4:0]] = 0;
                age[next_q[4:0]] = '0;
                retries[next_q[4:0]] = '0;
                run.push_back(send_result(next_q, 1'b0));
                next_q++;
            end
            for (int i = 0; i < 32; i++) begin
                if (age[i] != 16'hFFFF) age[i]++;
            end
            if (silence != 16'hFFFF) silence++;
            if (cmd == CMD_ERR) begin
                heard = 1;
                silence = '0;
                fstat = ST_SRV_ERR;
                done = 1;
            end else if (cmd == CMD_ACK) begin
                heard = 1;
                silence = '0;
                if ({1'b0, ack} >= base_q && {1'b0, ack} < next_q) acked[ack[4:0]] = 1;
                while (base_q < next_q && acked[base_q[4:0]]) begin
                    acked[base_q[4:0]] = 0;
                    base_q++;
                end
            end
        end
        if (!done) begin
            // Slots sent in this very period lie at or beyond old_next and are skipped.
            s = base_q;
            while (!done && s < old_next) begin
                if (!acked[s[4:0]] && age[s[4:0]] >= c_retx) begin
                    if (retries[s[4:0]] >= c_retry) begin
                        fstat = ST_RETRY;
                        done = 1;
                    end else begin
                        retries[s[4:0]]++;
                        age[s[4:0]] = '0;
                        run.push_back(send_result(s, 1'b1));
                    end
                end
                s++;
            end
            if (!done) begin
                if (silence >= c_srvto) fstat = heard ? ST_SRV_DOWN : ST_NO_SRV;
                if (fstat == ST_RUNNING && base_q > {1'b0, c_last}) fstat = ST_COMPLETE;
            end
        end
        st = '0;
        st.kind = KIND_STATUS;
        st.status = fstat;
        st.is_last = 1'b1;
        run.push_back(st);
        foreach (run[k]) begin
            run[k].wbase = base_q[31:0];
            expected_results.push_back(run[k]);
        end
    endfunction

    function automatic int idle_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // Input driver: a request is held until taken, then the next one follows a random gap, which may be zero.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_gap <= 0;
        end else if (in_ch.valid && !in_fire) begin
            in_ch.valid <= 1'b1;
        end else if (in_gap > 0) begin
            in_ch.valid <= 1'b0;
            in_gap <= in_gap - 1;
        end else if (pending_polls.size() > 0) begin
            poll_t p;
            p = pending_polls.pop_front();
            in_ch.command <= p.cmd;
            in_ch.ack_sequence <= p.ack;
            in_ch.valid <= 1'b1;
            in_gap <= idle_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Every accepted poll moves the mirror on by one period.
    always @(posedge i_clk) begin
        in_fire = in_ch.valid && in_ch.ready && i_rst_n;
        if (in_fire) advance_window(in_ch.command, in_ch.ack_sequence);
    end

    // Receiver back-pressure, with one long hold-off when the stimulus asks for it.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
            out_gap <= 0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            out_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ch.ready <= 1'b0;
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            out_gap <= idle_gap();
        end
    end

    // Result checker against the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            window_result_t got;
            window_result_t want;
            got = {out_ch.kind, out_ch.sequence_res, out_ch.packet_type,
                   out_ch.is_retransmission, out_ch.status, out_ch.window_base,
                   out_ch.is_last};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected request kind=%0d seq=%0d status=%0d",
                             got.kind, got.seq, got.status);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"ERROR: exp kind=%0d seq=%0d type=%0d retx=%0d st=%0d ",
                                  "base=%0d last=%0d, got kind=%0d seq=%0d type=%0d ",
                                  "retx=%0d st=%0d base=%0d last=%0d"},
                                 want.kind, want.seq, want.ptype, want.retx, want.status,
                                 want.wbase, want.is_last, got.kind, got.seq, got.ptype,
                                 got.retx, got.status, got.wbase, got.is_last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        case (idx)
            REG_LAST_SEQ: c_last = value;
            REG_WIN_SIZE: c_win = value[5:0];
            REG_RETX:     c_retx = value[15:0];
            REG_SRV_TO:   c_srvto = value[15:0];
            REG_RETRY:    c_retry = value[2:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_registers(input logic [31:0] last, input logic [5:0] win,
                                 input logic [15:0] retx, input logic [15:0] srvto,
                                 input logic [2:0] retry);
        write_reg(REG_LAST_SEQ, last);
        write_reg(REG_WIN_SIZE, {26'd0, win});
        write_reg(REG_RETX, {16'd0, retx});
        write_reg(REG_SRV_TO, {16'd0, srvto});
        write_reg(REG_RETRY, {29'd0, retry});
    endtask

    task automatic queue_poll(input logic [1:0] cmd, input logic [31:0] ack);
        while (pending_polls.size() >= 2) @(negedge i_clk);
        pending_polls.push_back('{cmd: cmd, ack: ack});
    endtask

    // Wait until the block has no request in hand and nothing is outstanding.
    task automatic drain();
        @(negedge i_clk);
        while (pending_polls.size() > 0 || in_ch.valid || expected_results.size() > 0)
            @(negedge i_clk);
    endtask

    // Mostly well-formed acknowledgements chosen from the current window,
    // with stray acknowledgements and bare ticks mixed in.
    task automatic random_polls(input int count);
        int          r;
        logic [32:0] span;
        repeat (count) begin
            @(negedge i_clk);
            while (pending_polls.size() >= 2) @(negedge i_clk);
            span = next_q - base_q;
            r = $urandom_range(0, 99);
            if (r < 45 && span != 0)
                queue_poll(CMD_ACK, base_q[31:0]);
            else if (r < 75 && span != 0)
                queue_poll(CMD_ACK, base_q[31:0] + $urandom_range(0, span - 1));
            else if (r < 85)
                queue_poll(CMD_ACK, $urandom);
            else if (r < 95)
                queue_poll(CMD_TICK, $urandom);
            else
                queue_poll(CMD_SPARE, $urandom);
        end
    endtask

    initial begin
        int guard;
        i_rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;
        in_ch.valid = 1'b0;
        in_ch.command = CMD_TICK;
        in_ch.ack_sequence = '0;
        out_ch.ready = 1'b0;
        mismatches = 0;
        cycles = 0;
        calm = 1;
        hold_req = 0;
        in_fire = 0;
        c_last = 32'd1;
        c_win = 6'd8;
        c_retx = 16'd15;
        c_srvto = 16'd600;
        c_retry = 3'd5;
        base_q = '0;
        next_q = '0;
        heard = 0;
        silence = '0;
        fstat = ST_RUNNING;
        for (int i = 0; i < 32; i++) begin
            acked[i] = 0;
            age[i] = '0;
            retries[i] = '0;
        end
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening: a short transfer of six packets through a window of four,
        // covering start and fin types, stray and repeated acknowledgements, an
        // acknowledgement ahead of the base, and resends of timed-out slots.
        set_registers(32'd5, 6'd4, 16'd6, 16'd200, 3'd7);
        queue_poll(CMD_TICK, 32'd0);
        queue_poll(CMD_SPARE, 32'hFFFF_FFFF);
        queue_poll(CMD_ACK, 32'hFFFF_FFFF);
        queue_poll(CMD_ACK, 32'd2);
        queue_poll(CMD_ACK, 32'd0);
        queue_poll(CMD_ACK, 32'd1);
        queue_poll(CMD_ACK, 32'd2);
        repeat (4) queue_poll(CMD_TICK, 32'd0);
        queue_poll(CMD_ACK, 32'd3);
        queue_poll(CMD_ACK, 32'd4);
        repeat (4) queue_poll(CMD_TICK, 32'h5555_AAAA);
        drain();

        // Full-depth window with random idling; the receiver stalls for a long
        // stretch at the start so that the block backs up onto its input.
        calm = 0;
        set_registers(32'd1000000, 6'd32, 16'd40, 16'd200, 3'd7);
        hold_req = ~hold_req;
        random_polls(40);
        drain();

        // Window size zero behaves as one; the fin sits at the top of the range
        // and resends are effectively disabled, so a zero retry limit is safe.
        set_registers(32'hFFFF_FFFF, 6'd0, 16'hFFFF, 16'hFFFF, 3'd0);
        random_polls(30);
        drain();

        // Oversized window, clamped to the depth.
        set_registers(32'd1000000, 6'd63, 16'd30, 16'd1000, 3'd7);
        random_polls(30);
        drain();

        // Shrink the transfer below the send point and acknowledge until it completes,
        // then poll a finished session, including a server error that must be ignored.
        write_reg(REG_LAST_SEQ, next_q[31:0] - 32'd1);
        guard = 0;
        while (fstat == ST_RUNNING && guard < 120) begin
            queue_poll(CMD_ACK, base_q[31:0]);
            @(negedge i_clk);
            guard++;
        end
        queue_poll(CMD_ERR, 32'd0);
        queue_poll(CMD_TICK, 32'd0);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/srsw_pkg.sv
rtl/srsw_ifs.sv
rtl/srsw_ctrl.sv
rtl/srsw_dp.sv
rtl/selective_repeat_sender_window_unit.sv
rtl/srsw_checker.sv
bench/tb_selective_repeat_sender_window_unit.sv
